@@ rtl/rfop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_pkg
// Shared types and constants for the rectangle fill/outline pixel generator.
// ----------------------------------------------------------------------------
package rfop_pkg;

	localparam int unsigned SCREEN_COLS = 160;
	localparam int unsigned SCREEN_ROWS = 128;

	localparam int unsigned COORD_W = 10;
	localparam int unsigned SIZE_W  = 11;
	localparam int unsigned SUM_W   = 12;
	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned PIX_W   = 16;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [SIZE_W-1:0]  rect_width;
		logic [SIZE_W-1:0]  rect_height;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               fill_mode;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pixel_address;
		logic [PIX_W-1:0]  pixel_value;
		logic              write_pixel;
		logic              last_pixel;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} pix_result_t;

	function automatic logic [PIX_W-1:0] to_rgb565(input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

@@ rtl/rfop_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_scan
// Rectangle setup and raster scan: latches a clipped rectangle on a valid start
// while enabled and produces one pixel per step transfer during a scan.
// ----------------------------------------------------------------------------
module rfop_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  rfop_pkg::in_item_t in_item,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output rfop_pkg::pix_result_t result
);
	import rfop_pkg::*;

	logic               enable_q;
	logic               busy_q, busy_d;
	logic [COORD_W-1:0] cur_x_q, cur_x_d;
	logic [COORD_W-1:0] cur_y_q, cur_y_d;
	logic [COORD_W-1:0] left_q, left_d;
	logic [COORD_W-1:0] top_q, top_d;
	logic [COORD_W-1:0] right_q, right_d;
	logic [COORD_W-1:0] bottom_q, bottom_d;
	logic [PIX_W-1:0]   colour_q, colour_d;
	logic               fill_q, fill_d;

	logic [SUM_W-1:0]   x_far, y_far;
	logic               geom_ok;
	logic               at_right, at_bottom, on_edge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			busy_q   <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			colour_q <= '0;
			fill_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			busy_q   <= busy_d;
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			left_q   <= left_d;
			top_q    <= top_d;
			right_q  <= right_d;
			bottom_q <= bottom_d;
			colour_q <= colour_d;
			fill_q   <= fill_d;
		end
	end

	assign x_far = SUM_W'(in_item.x0) + SUM_W'(in_item.rect_width) - SUM_W'(1);
	assign y_far = SUM_W'(in_item.y0) + SUM_W'(in_item.rect_height) - SUM_W'(1);
	assign geom_ok = (in_item.rect_width != '0) && (in_item.rect_height != '0) &&
		(SUM_W'(in_item.x0) < SUM_W'(SCREEN_COLS)) &&
		(SUM_W'(in_item.y0) < SUM_W'(SCREEN_ROWS));

	assign at_right  = (cur_x_q == right_q);
	assign at_bottom = (cur_y_q == bottom_q);
	assign on_edge   = (cur_x_q == left_q) || at_right || (cur_y_q == top_q) || at_bottom;

	always_comb begin
		busy_d   = busy_q;
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		left_d   = left_q;
		top_d    = top_q;
		right_d  = right_q;
		bottom_d = bottom_q;
		colour_d = colour_q;
		fill_d   = fill_q;

		result.valid              = 1'b0;
		result.item.pixel_address = ADDR_W'(cur_x_q) +
			ADDR_W'(cur_y_q) * ADDR_W'(SCREEN_COLS);
		result.item.pixel_value   = colour_q;
		result.item.write_pixel   = fill_q || on_edge;
		result.item.last_pixel    = at_right && at_bottom;

		if (accept) begin
			case (in_item.cmd)
				CMD_START: begin
					// drop starts while disabled; a running scan continues
					if (enable_q) begin
						busy_d = 1'b0;
						if (geom_ok) begin
							busy_d   = 1'b1;
							left_d   = in_item.x0;
							top_d    = in_item.y0;
							cur_x_d  = in_item.x0;
							cur_y_d  = in_item.y0;
							right_d  = (x_far > SUM_W'(SCREEN_COLS - 1)) ?
								COORD_W'(SCREEN_COLS - 1) : x_far[COORD_W-1:0];
							bottom_d = (y_far > SUM_W'(SCREEN_ROWS - 1)) ?
								COORD_W'(SCREEN_ROWS - 1) : y_far[COORD_W-1:0];
							colour_d = to_rgb565(in_item.red, in_item.green, in_item.blue);
							fill_d   = in_item.fill_mode;
						end
					end
				end
				CMD_STEP: begin
					if (busy_q) begin
						result.valid = 1'b1;
						if (at_right) begin
							cur_x_d = left_q;
							if (at_bottom) begin
								busy_d = 1'b0;
							end else begin
								cur_y_d = cur_y_q + COORD_W'(1);
							end
						end else begin
							cur_x_d = cur_x_q + COORD_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pos_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_x_q >= left_q) && (cur_x_q <= right_q) &&
			(cur_y_q >= top_q) && (cur_y_q <= bottom_q))
		else $error("scan position outside latched rectangle");
	a_edges_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (SUM_W'(right_q) < SUM_W'(SCREEN_COLS)) &&
			(SUM_W'(bottom_q) < SUM_W'(SCREEN_ROWS)))
		else $error("clipped corner off screen");
	a_result_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> busy_q && accept)
		else $error("pixel produced while idle");
	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.item.last_pixel |=> !busy_q)
		else $error("scan continues after final pixel");
`endif

endmodule

@@ rtl/rfop_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_out_buf
// Result register with a skid stage, so input transfers continue while one
// pixel waits on the output.
// ----------------------------------------------------------------------------
module rfop_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfop_pkg::pix_result_t result,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rfop_pkg::out_item_t   out_data
);
	import rfop_pkg::*;

	logic      main_valid_s2;
	out_item_t main_s2;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = main_valid_s2 && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = main_valid_s2;
	assign out_data  = main_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_s2 <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					main_valid_s2 <= 1'b1;
					skid_valid_q  <= 1'b0;
				end else begin
					main_valid_s2 <= result.valid;
				end
			end else if (!main_valid_s2) begin
				main_valid_s2 <= result.valid;
			end else if (result.valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_s2 <= skid_q;
		end else if (pop || !main_valid_s2) begin
			main_s2 <= result.item;
		end
		// park the new pixel while the output stalls
		if (main_valid_s2 && !pop && !skid_valid_q) begin
			skid_q <= result.item;
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_s2)
		else $error("skid holds data with empty output register");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !skid_valid_q)
		else $error("pixel arrived with both stages full");
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_s2 && !out_ready))
		else $error("skid filled without an output stall");
`endif

endmodule

@@ rtl/rect_fill_outline_pixel_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_outline_pixel_generator_unit
// Clips a rectangle to the screen and emits one RGB565 framebuffer pixel per
// step transfer of a running scan in raster order, fill or outline.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle, one pixel per cycle, while in_ready and out_ready stay high.
// A step's pixel is registered in the result register, or in the skid while the output stalls.
// A two-deep output stage (result register plus skid) decouples the sides;
// in_ready drops only while both stages hold pixels.
// Reset: arst_n clears enable, scan state and output valids asynchronously.
module rect_fill_outline_pixel_generator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rfop_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rfop_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import rfop_pkg::*;

	pix_result_t result;
	logic        room;
	logic        accept;

	assign in_ready = room;
	assign accept   = in_valid && room;

	rfop_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	rfop_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ dv/rect_fill_outline_pixel_generator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_outline_pixel_generator_unit_test
// Drives start and step transfers into the rectangle pixel generator and checks
// every pixel against a raster-scan predictor. Covers fill and outline modes,
// clipping, empty and off-screen rectangles, restarts and the enable register.
// Both sides add random gaps to the transfers outside steady batches.
// ----------------------------------------------------------------------------
module rect_fill_outline_pixel_generator_unit_test;
	import rfop_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned TAIL_CYCLES   = 4;
	localparam int unsigned RANDOM_ITEMS  = 2000;
	localparam int unsigned MAX_SCAN_LEN  = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	// predictor state
	bit          enable_shadow;
	bit          scan_active;
	logic [9:0]  col, row, left_col, top_row, right_col, bottom_row;
	logic [15:0] held_rgb565;
	bit          held_solid;

	out_item_t   pending_pixels[$];
	int unsigned mismatch_count;
	int unsigned sent_items;
	int unsigned cycle_count;
	int unsigned rx_hold;
	bit          tx_steady;
	bit          rx_steady;

	rect_fill_outline_pixel_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// receiver back-pressure
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (!rx_steady && $urandom_range(99) < 25) begin
			rx_hold <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		$display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_pixels
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel at address", out_data.pixel_address, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.pixel_address !== want.pixel_address)
					report_mismatch("pixel_address", out_data.pixel_address,
						want.pixel_address);
				if (out_data.pixel_value !== want.pixel_value)
					report_mismatch("pixel_value", out_data.pixel_value, want.pixel_value);
				if (out_data.write_pixel !== want.write_pixel)
					report_mismatch("write_pixel", out_data.write_pixel, want.write_pixel);
				if (out_data.last_pixel !== want.last_pixel)
					report_mismatch("last_pixel", out_data.last_pixel, want.last_pixel);
			end
		end
	end

	// Raster-scan predictor: update state for one accepted transfer and queue
	// the pixel it produces, if any.
	task automatic advance_raster(input in_item_t it);
		int unsigned far_col;
		int unsigned far_row;
		out_item_t   px;
		if (it.cmd == CMD_START) begin
			if (!enable_shadow)
				return;
			scan_active = 1'b0;
			if (it.rect_width == 0 || it.rect_height == 0 ||
				it.x0 >= SCREEN_COLS || it.y0 >= SCREEN_ROWS)
				return;
			far_col = int'(it.x0) + int'(it.rect_width) - 1;
			far_row = int'(it.y0) + int'(it.rect_height) - 1;
			if (far_col > SCREEN_COLS - 1)
				far_col = SCREEN_COLS - 1;
			if (far_row > SCREEN_ROWS - 1)
				far_row = SCREEN_ROWS - 1;
			left_col    = it.x0;
			top_row     = it.y0;
			right_col   = far_col[9:0];
			bottom_row  = far_row[9:0];
			col         = it.x0;
			row         = it.y0;
			held_rgb565 = PIX_W'(((int'(it.red) >> 3) << 11) | ((int'(it.green) >> 2) << 5) |
				(int'(it.blue) >> 3));
			held_solid  = it.fill_mode;
			scan_active = 1'b1;
			return;
		end
		if (!scan_active)
			return;
		px.pixel_address = ADDR_W'(int'(col) + int'(row) * SCREEN_COLS);
		px.pixel_value   = held_rgb565;
		px.write_pixel   = held_solid || col == left_col || col == right_col ||
			row == top_row || row == bottom_row;
		px.last_pixel    = (col == right_col) && (row == bottom_row);
		pending_pixels.push_back(px);
		if (col == right_col) begin
			col = left_col;
			if (row == bottom_row)
				scan_active = 1'b0;
			else
				row = row + 10'd1;
		end else begin
			col = col + 10'd1;
		end
	endtask

	function automatic in_item_t start_item(int unsigned x, int unsigned y, int unsigned w,
		int unsigned h, int unsigned r, int unsigned g, int unsigned b, bit fill);
		in_item_t it;
		it.cmd         = CMD_START;
		it.x0          = COORD_W'(x);
		it.y0          = COORD_W'(y);
		it.rect_width  = SIZE_W'(w);
		it.rect_height = SIZE_W'(h);
		it.red         = 8'(r);
		it.green       = 8'(g);
		it.blue        = 8'(b);
		it.fill_mode   = fill;
		return it;
	endfunction

	// step with junk in the unused fields
	function automatic in_item_t step_item();
		in_item_t it;
		it = start_item($urandom_range(1023), $urandom_range(1023), $urandom_range(1024),
			$urandom_range(1024), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(1));
		it.cmd = CMD_STEP;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sent_items++;
		advance_raster(it);
	endtask

	task automatic send_steps(input int unsigned n);
		repeat (n) send_item(step_item());
	endtask

	// hold the sender until all pixels are back, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input bit value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		enable_shadow = value;
	endtask

	task automatic test_start_while_disabled();
		send_item(start_item(0, 0, 4, 4, 255, 255, 255, 1'b1));
		send_steps(1);
		wait_idle();
	endtask

	task automatic test_fill_mode();
		send_item(start_item(5, 7, 2, 2, 255, 255, 255, 1'b1));
		send_steps(4);
		wait_idle();
	endtask

	task automatic test_outline_mode();
		send_item(start_item(0, 0, 3, 3, 8'h88, 8'h44, 8'h18, 1'b0));
		send_steps(9);
		wait_idle();
	endtask

	task automatic test_clipping();
		send_item(start_item(SCREEN_COLS - 1, SCREEN_ROWS - 1, 1024, 1024, 0, 0, 0, 1'b0));
		send_steps(2);
		wait_idle();
	endtask

	task automatic test_empty_rects();
		send_item(start_item(10, 10, 0, 5, 1, 2, 3, 1'b1));
		send_item(start_item(10, 10, 5, 0, 1, 2, 3, 1'b1));
		send_item(start_item(SCREEN_COLS, 0, 4, 4, 1, 2, 3, 1'b1));
		send_item(start_item(0, 1023, 4, 4, 1, 2, 3, 1'b1));
		send_steps(1);
		wait_idle();
	endtask

	task automatic test_restart_while_busy();
		send_item(start_item(10, 10, 3, 1, 200, 100, 50, 1'b1));
		send_steps(1);
		send_item(start_item(20, 30, 1, 1, 7, 9, 250, 1'b0));
		send_steps(2);
		wait_idle();
	endtask

	task automatic test_enable_cleared_mid_scan();
		send_item(start_item(100, 50, 1, 3, 30, 60, 90, 1'b1));
		send_steps(1);
		wait_idle();
		cfg_write(1'b0);
		send_item(start_item(0, 0, 2, 2, 0, 0, 0, 1'b1));
		send_steps(3);
		wait_idle();
		cfg_write(1'b1);
	endtask

	function automatic int unsigned pick_origin(int unsigned extent);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(extent - 1);
		if (r < 85)
			return $urandom_range(extent - 1, extent - 8);
		return $urandom_range(1023);
	endfunction

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return 0;
		if (r < 75)
			return $urandom_range(6, 1);
		if (r < 88)
			return $urandom_range(1024);
		return 1024;
	endfunction

	task automatic test_random_traffic();
		int unsigned r;
		int unsigned scan_len;
		int unsigned batch_sent;
		bit          first_batch;
		first_batch = 1'b1;
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			wait_idle();
			cfg_write(first_batch || $urandom_range(99) < 80);
			first_batch = 1'b0;
			tx_steady = ($urandom_range(99) < 25);
			rx_steady = ($urandom_range(99) < 25);
			batch_sent = 0;
			while (batch_sent < 250 && sent_items < RANDOM_ITEMS) begin
				r = $urandom_range(99);
				if (r < 75) begin
					send_item(start_item(pick_origin(SCREEN_COLS), pick_origin(SCREEN_ROWS),
						pick_size(), pick_size(), $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(1)));
					scan_len = 0;
					if (scan_active)
						scan_len = (int'(right_col) - int'(left_col) + 1) *
							(int'(bottom_row) - int'(top_row) + 1);
					// long scans get cut short by the next start
					if (scan_len > MAX_SCAN_LEN)
						scan_len = $urandom_range(MAX_SCAN_LEN, 1);
					else
						scan_len += $urandom_range(1);
					send_steps(scan_len);
					batch_sent += scan_len + 1;
				end else if (r < 90) begin
					send_item(start_item($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1024), $urandom_range(1024), $urandom_range(255),
						$urandom_range(255), $urandom_range(255), $urandom_range(1)));
					batch_sent++;
				end else if (r < 97) begin
					scan_len = $urandom_range(3, 1);
					send_steps(scan_len);
					batch_sent += scan_len;
				end else begin
					wait_idle();
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_while_disabled();
		cfg_write(1'b1);
		test_fill_mode();
		test_outline_mode();
		test_clipping();
		test_empty_rects();
		test_restart_while_busy();
		test_enable_cleared_mid_scan();
		test_random_traffic();
		wait_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
